FILE: design/wcwa_pkg.sv
// Shared types and constants for the weekday clock with alarm.
// Holds the transfer payload structs, clock state, configuration set and codes.
// No dependencies.
package wcwa_pkg;

	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
	localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
	localparam logic [2:0] DAYS_PER_WEEK      = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKLIGHT_SECONDS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_BATTERY_LEVEL  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_BATTERY_LEVEL = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_MINUTE       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_HOUR         = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_WEEKDAY      = 3'd5;

	// Configuration reset values.
	localparam logic [5:0] BACKLIGHT_SECONDS_RST  = 6'd10;
	localparam logic [7:0] LOW_BATTERY_LEVEL_RST  = 8'd183;
	localparam logic [7:0] HIGH_BATTERY_LEVEL_RST = 8'd210;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_LOAD    = 3'd1,
		ACT_BUTTON  = 3'd2,
		ACT_BATTERY = 3'd3,
		ACT_ARM     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		CHARGE_LOW    = 2'd0,
		CHARGE_MEDIUM = 2'd1,
		CHARGE_FULL   = 2'd2
	} charge_t;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] set_second;
		logic [5:0] set_minute;
		logic [4:0] set_hour;
		logic [2:0] set_weekday;
		logic [7:0] battery_reading;
		logic       arm_value;
	} item_t;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic       backlight_lit;
		logic       buzzer;
		logic       alarm_sounding;
		logic [1:0] charge_level;
	} result_t;

	typedef struct packed {
		logic [5:0] backlight_seconds;
		logic [7:0] low_battery_level;
		logic [7:0] high_battery_level;
		logic [5:0] alarm_minute;
		logic [4:0] alarm_hour;
		logic [2:0] alarm_weekday;
	} cfg_t;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic       light_idle;
		logic [5:0] light_off_second;
		logic       alarm_armed;
		logic       buzzer_level;
		logic       battery_low;
		charge_t    charge_state;
	} clk_state_t;

endpackage

FILE: design/wcwa_step.sv
// Next-state and result logic for one item of the weekday clock.
// Purely combinational; depends on wcwa_pkg.
module wcwa_step (
	input  wcwa_pkg::clk_state_t state,
	input  wcwa_pkg::cfg_t       cfg,
	input  wcwa_pkg::item_t      item,
	output wcwa_pkg::clk_state_t next_state,
	output wcwa_pkg::result_t    result
);
	import wcwa_pkg::*;

	function automatic logic sounding(input clk_state_t st, input cfg_t c);
		logic match;
		match = st.alarm_armed && (st.weekday == c.alarm_weekday) &&
			(st.hour == c.alarm_hour) && (st.minute == c.alarm_minute);
		return match || st.battery_low;
	endfunction

	logic       snd_before;
	logic [6:0] off_sum;
	logic [6:0] off_wrapped;
	clk_state_t upd;

	assign snd_before = sounding(state, cfg);

	// The sum reaches at most 122, so two conditional subtractions reduce it modulo 60.
	always_comb begin
		off_sum = {1'b0, state.second} + {1'b0, cfg.backlight_seconds};
		priority if (off_sum >= {SECONDS_PER_MINUTE, 1'b0}) begin
			off_wrapped = off_sum - {SECONDS_PER_MINUTE, 1'b0};
		end else if (off_sum >= {1'b0, SECONDS_PER_MINUTE}) begin
			off_wrapped = off_sum - {1'b0, SECONDS_PER_MINUTE};
		end else begin
			off_wrapped = off_sum;
		end
	end

	always_comb begin
		upd = state;
		unique case (action_t'(item.action))
			ACT_TICK: begin
				upd.buzzer_level = snd_before ? !state.buzzer_level : 1'b0;
				if (state.second >= SECONDS_PER_MINUTE - 6'd1) begin
					upd.second = '0;
					if (state.minute >= MINUTES_PER_HOUR - 6'd1) begin
						upd.minute = '0;
						if (state.hour >= HOURS_PER_DAY - 5'd1) begin
							upd.hour = '0;
							upd.weekday = (state.weekday >= DAYS_PER_WEEK - 3'd1) ?
								3'd0 : state.weekday + 3'd1;
						end else begin
							upd.hour = state.hour + 5'd1;
						end
					end else begin
						upd.minute = state.minute + 6'd1;
					end
				end else begin
					upd.second = state.second + 6'd1;
				end
			end
			ACT_LOAD: begin
				upd.second  = (item.set_second >= SECONDS_PER_MINUTE) ? 6'd0 : item.set_second;
				upd.minute  = (item.set_minute >= MINUTES_PER_HOUR) ? 6'd0 : item.set_minute;
				upd.hour    = (item.set_hour >= HOURS_PER_DAY) ? 5'd0 : item.set_hour;
				upd.weekday = (item.set_weekday >= DAYS_PER_WEEK) ? 3'd0 : item.set_weekday;
			end
			ACT_BUTTON: begin
				if (state.light_idle) begin
					upd.light_off_second = off_wrapped[5:0];
					upd.light_idle = 1'b0;
				end else if (snd_before) begin
					upd.alarm_armed = 1'b0;
				end
			end
			ACT_BATTERY: begin
				priority if (item.battery_reading >= cfg.high_battery_level) begin
					upd.charge_state = CHARGE_FULL;
					upd.battery_low = 1'b0;
				end else if (item.battery_reading <= cfg.low_battery_level) begin
					upd.charge_state = CHARGE_LOW;
					upd.battery_low = 1'b1;
				end else begin
					upd.charge_state = CHARGE_MEDIUM;
					upd.battery_low = 1'b0;
				end
			end
			ACT_ARM: begin
				upd.alarm_armed = item.arm_value;
			end
			default: begin
			end
		endcase
	end

	// The backlight timeout ends after any item, including one that has just started it.
	always_comb begin
		next_state = upd;
		if (!upd.light_idle && (upd.second == upd.light_off_second)) begin
			next_state.light_idle = 1'b1;
		end
	end

	assign result.second         = next_state.second;
	assign result.minute         = next_state.minute;
	assign result.hour           = next_state.hour;
	assign result.weekday        = next_state.weekday;
	assign result.backlight_lit  = !next_state.light_idle;
	assign result.buzzer         = next_state.buzzer_level;
	assign result.alarm_sounding = sounding(next_state, cfg);
	assign result.charge_level   = next_state.charge_state;

endmodule

FILE: design/weekday_clock_with_alarm_top.sv
// Top level of the weekday clock with alarm: input register, clock state, result register.
// Depends on wcwa_pkg and wcwa_step.
//
//   channel   handshake                    payload
//   item      item_valid / item_ready      item   (wcwa_pkg::item_t)
//   result    result_valid / result_ready  result (wcwa_pkg::result_t)
//   config    cfg_we                       cfg_index, cfg_data
//
// One item per cycle unless the result stalls; each result passes the input register and then
// the result register, the step logic between them being one short compare and carry update.
// Reset clears the clock state, the configuration to its defaults and both valid flags.
// A stalled result holds while item_ready stays high as long as the input register is free.
module weekday_clock_with_alarm_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  wcwa_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output wcwa_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [wcwa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wcwa_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wcwa_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       advance;
	cfg_t       cfg_q;
	clk_state_t state_q;
	clk_state_t state_next;
	result_t    result_next;
	logic       result_valid_q;
	result_t    result_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backlight_seconds  <= BACKLIGHT_SECONDS_RST;
			cfg_q.low_battery_level  <= LOW_BATTERY_LEVEL_RST;
			cfg_q.high_battery_level <= HIGH_BATTERY_LEVEL_RST;
			cfg_q.alarm_minute       <= '0;
			cfg_q.alarm_hour         <= '0;
			cfg_q.alarm_weekday      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BACKLIGHT_SECONDS:  cfg_q.backlight_seconds  <= cfg_data[5:0];
				CFG_LOW_BATTERY_LEVEL:  cfg_q.low_battery_level  <= cfg_data;
				CFG_HIGH_BATTERY_LEVEL: cfg_q.high_battery_level <= cfg_data;
				CFG_ALARM_MINUTE:       cfg_q.alarm_minute       <= cfg_data[5:0];
				CFG_ALARM_HOUR:         cfg_q.alarm_hour         <= cfg_data[4:0];
				CFG_ALARM_WEEKDAY:      cfg_q.alarm_weekday      <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	wcwa_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.item       (item_s1),
		.next_state (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.second           <= '0;
			state_q.minute           <= '0;
			state_q.hour             <= '0;
			state_q.weekday          <= '0;
			state_q.light_idle       <= 1'b1;
			state_q.light_off_second <= '0;
			state_q.alarm_armed      <= 1'b0;
			state_q.buzzer_level     <= 1'b0;
			state_q.battery_low      <= 1'b0;
			state_q.charge_state     <= CHARGE_LOW;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Loads and carries must keep the time within its ranges.
	a_time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.second < SECONDS_PER_MINUTE) &&
			(result_q.minute < MINUTES_PER_HOUR) && (result_q.hour < HOURS_PER_DAY) &&
			(result_q.weekday < DAYS_PER_WEEK))
		else $error("result time out of range");

	// A low battery is only ever recorded together with the low charge level.
	a_low_battery_charge: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.battery_low |-> (state_q.charge_state == CHARGE_LOW))
		else $error("battery low flag disagrees with charge level");

	// An item in the input register moves on at once when the result register is empty.
	a_item_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !result_valid_q) |=> result_valid_q)
		else $error("item held back with an empty result register");

	// The charge level is only ever one of the three defined codes.
	a_charge_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.charge_level != 2'd3))
		else $error("invalid charge level");

endmodule
